/* hdl/tle_pkg.sv */
package tle_pkg;

  // Operation codes of an input item
  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_CHAR  = 2'd2;
  localparam logic [1:0] OP_END   = 2'd3;

  // Layout modes; the unused code behaves as measure
  localparam logic [1:0] MODE_PLAIN   = 2'd0;
  localparam logic [1:0] MODE_CLIPPED = 2'd1;
  localparam logic [1:0] MODE_MEASURE = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_LAYOUT_MODE   = 2'd0;
  localparam logic [1:0] CFG_DISPLAY_WIDTH = 2'd1;

  localparam logic [1:0]  LAYOUT_MODE_RST   = MODE_PLAIN;
  localparam logic [11:0] DISPLAY_WIDTH_RST = 12'd320;

  // Character code of glyph 0, and the glyph of the dot
  localparam logic [7:0] FIRST_CODE = 8'd32;
  localparam int unsigned DOT_GLYPH = 14;
  localparam logic [1:0] DOT_COUNT  = 2'd3;

  localparam logic RES_DRAW = 1'b0;
  localparam logic RES_DONE = 1'b1;

  typedef struct packed {
    logic [1:0]         operation;
    logic [7:0]         char_code;
    logic [7:0]         glyph_width;
    logic signed [15:0] start_x;
    logic signed [15:0] start_y;
  } in_item_t;

  typedef struct packed {
    logic               result_kind;
    logic [6:0]         glyph_index;
    logic signed [15:0] pen_x;
    logic signed [15:0] pen_y;
    logic [15:0]        total_width;
    logic               was_truncated;
    logic               last_result;
  } out_item_t;

  // Request from the layout stage to the result sequencer
  typedef struct packed {
    logic               valid;
    logic               is_end;
    logic               trunc;
    logic [6:0]         glyph;
    logic [15:0]        total;
    logic signed [15:0] pen_y;
  } emit_req_t;

endpackage

/* hdl/text_layout_with_ellipsis.sv */
// An accepted item passes through the lookup stage, then the result register. Throughput:
// one item per cycle while the result sequencer takes requests, set by the width
// table's single registered read; an end item in clipped mode that truncates
// holds the result register for three dots and the done report.
// Reset clears pen, budget, sum and control state; layout_mode resets to plain
// and display_width to 320. The glyph width table is not cleared.
module text_layout_with_ellipsis
  import tle_pkg::*;
#(
  parameter int GLYPH_COUNT = 96,
  parameter int COORD_BITS  = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  in_item_t   in_item_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output out_item_t  out_item_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic [11:0] cfg_data_i
);

  localparam int AW = (GLYPH_COUNT > 1) ? $clog2(GLYPH_COUNT) : 1;
  localparam bit HAS_DOT = (GLYPH_COUNT > DOT_GLYPH);
  localparam logic signed [32:0] PEN_MAX_W = (33'sd1 <<< (COORD_BITS - 1)) - 33'sd1;
  localparam logic signed [32:0] PEN_MIN_W = -PEN_MAX_W - 33'sd1;
  localparam logic [COORD_BITS-1:0] PEN_MAX = {1'b0, {(COORD_BITS - 1){1'b1}}};

  // Clamp a 16-bit coordinate to the pen range
  function automatic logic [COORD_BITS-1:0] sat_coord(input logic signed [15:0] v);
    logic signed [32:0] wide;
    wide = 33'(v);
    if (wide > PEN_MAX_W) begin
      return PEN_MAX_W[COORD_BITS-1:0];
    end else if (wide < PEN_MIN_W) begin
      return PEN_MIN_W[COORD_BITS-1:0];
    end
    return wide[COORD_BITS-1:0];
  endfunction

  // Configuration registers
  logic [1:0]  mode_q;
  logic [11:0] disp_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= LAYOUT_MODE_RST;
      disp_q <= DISPLAY_WIDTH_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_LAYOUT_MODE:   mode_q <= cfg_data_i[1:0];
        CFG_DISPLAY_WIDTH: disp_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Input stage: decode the item and issue the table access
  logic       in_accept;
  logic [7:0] g_in;
  logic       g_ok_in;
  logic       load_ok;
  logic       tbl_we;
  logic       tbl_re;
  logic [7:0] tbl_rdata;
  logic [7:0] dot_w_q;

  assign in_accept = in_valid_i && !in_stall_o;
  assign g_in      = in_item_i.char_code - FIRST_CODE;
  assign g_ok_in   = (in_item_i.char_code >= FIRST_CODE)
                     && ({1'b0, g_in} < 9'(GLYPH_COUNT));
  assign load_ok   = {1'b0, in_item_i.char_code} < 9'(GLYPH_COUNT);
  assign tbl_we    = in_accept && (in_item_i.operation == OP_LOAD) && load_ok;
  assign tbl_re    = in_accept && (in_item_i.operation == OP_CHAR);

  tle_ram #(
    .WIDTH (8),
    .DEPTH (GLYPH_COUNT),
    .AW    (AW)
  ) u_width_ram (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (in_item_i.char_code[AW-1:0]),
    .wdata_i (in_item_i.glyph_width),
    .re_i    (tbl_re),
    .raddr_i (g_in[AW-1:0]),
    .rdata_o (tbl_rdata)
  );

  // Keep a copy of the dot width for start and end items
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dot_w_q <= 8'd0;
    end else if (HAS_DOT && tbl_we && (in_item_i.char_code == 8'(DOT_GLYPH))) begin
      dot_w_q <= in_item_i.glyph_width;
    end
  end

  // Layout stage registers
  logic               s1_valid_q;
  logic [1:0]         s1_op_q;
  logic [7:0]         s1_g_q;
  logic               s1_ok_q;
  logic signed [15:0] s1_sx_q;
  logic signed [15:0] s1_sy_q;
  logic               s1_adv;
  logic               s1_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_op_q <= in_item_i.operation;
      s1_g_q  <= g_in;
      s1_ok_q <= g_ok_in;
      s1_sx_q <= in_item_i.start_x;
      s1_sy_q <= in_item_i.start_y;
    end
  end

  // Text state
  logic [COORD_BITS-1:0] pen_x_q, pen_x_d;
  logic signed [15:0]    pen_y_q, pen_y_d;
  logic signed [17:0]    budget_q, budget_d;
  logic [15:0]           sum_q, sum_d;

  logic                  clipped;
  logic                  draws;
  logic                  budget_pos;
  logic signed [17:0]    budget_sub;
  logic [9:0]            dot_w3;
  logic [COORD_BITS:0]   px_sum;
  logic [COORD_BITS-1:0] px_adv;
  logic [16:0]           sum_wide;
  logic [31:0]           py_wide;
  logic                  needs_out;
  logic                  emit_ready;
  emit_req_t             req;

  assign clipped    = (mode_q == MODE_CLIPPED);
  assign draws      = (mode_q == MODE_PLAIN) || clipped;
  assign budget_pos = (budget_q > 18'sd0);
  assign budget_sub = budget_q - $signed({10'd0, tbl_rdata});
  assign dot_w3     = {2'd0, dot_w_q} + {1'b0, dot_w_q, 1'b0};
  assign py_wide    = 32'($signed(sat_coord(s1_sy_q)));

  // Pen advance and sum, both saturating
  always_comb begin
    px_sum   = {pen_x_q[COORD_BITS-1], pen_x_q} + (COORD_BITS + 1)'(tbl_rdata);
    px_adv   = (px_sum[COORD_BITS] != px_sum[COORD_BITS-1]) ? PEN_MAX
                                                             : px_sum[COORD_BITS-1:0];
    sum_wide = {1'b0, sum_q} + {9'd0, tbl_rdata};
  end

  // Work out the next state and the result request for the held item
  always_comb begin
    pen_x_d    = pen_x_q;
    pen_y_d    = pen_y_q;
    budget_d   = budget_q;
    sum_d      = sum_q;
    needs_out  = 1'b0;
    req        = '0;
    req.glyph  = s1_g_q[6:0];
    req.total  = sum_q;
    req.pen_y  = pen_y_q;
    unique case (s1_op_q)
      OP_LOAD: ;
      OP_START: begin
        pen_x_d  = sat_coord(s1_sx_q);
        pen_y_d  = py_wide[15:0];
        sum_d    = 16'd0;
        budget_d = $signed({6'd0, disp_q}) - 18'(s1_sx_q) - $signed({8'd0, dot_w3});
      end
      OP_CHAR: begin
        if (s1_ok_q && (!clipped || budget_pos)) begin
          if (clipped) begin
            budget_d = budget_sub;
          end
          if (!clipped || (budget_sub > 18'sd0)) begin
            needs_out = draws && (s1_g_q != 8'd0);
            pen_x_d   = px_adv;
            sum_d     = sum_wide[16] ? 16'hFFFF : sum_wide[15:0];
          end
        end
      end
      OP_END: begin
        needs_out  = 1'b1;
        req.is_end = 1'b1;
        req.trunc  = clipped && !budget_pos;
      end
      default: ;
    endcase
    req.valid = s1_valid_q && needs_out;
  end

  assign s1_adv     = !s1_valid_q || !needs_out || emit_ready;
  assign s1_fire    = s1_valid_q && s1_adv;
  assign in_stall_o = s1_valid_q && !s1_adv;

  // Commit the state when the held item leaves the stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pen_x_q  <= '0;
      pen_y_q  <= '0;
      budget_q <= '0;
      sum_q    <= '0;
    end else if (s1_fire) begin
      pen_x_q  <= pen_x_d;
      pen_y_q  <= pen_y_d;
      budget_q <= budget_d;
      sum_q    <= sum_d;
    end
  end

  tle_emit #(
    .COORD_BITS (COORD_BITS)
  ) u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req),
    .pen_x_i     (pen_x_q),
    .dot_w_i     (dot_w_q),
    .ready_o     (emit_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

/* hdl/tle_ram.sv */
module tle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 96,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/tle_emit.sv */
module tle_emit
  import tle_pkg::*;
#(
  parameter int COORD_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  emit_req_t             req_i,
  input  logic [COORD_BITS-1:0] pen_x_i,
  input  logic [7:0]            dot_w_i,
  output logic                  ready_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_item_t             out_item_o
);

  localparam logic [COORD_BITS-1:0] PEN_MAX = {1'b0, {(COORD_BITS - 1){1'b1}}};

  logic                  ov_q;
  logic [1:0]            cnt_q;
  logic                  is_end_q;
  logic                  trunc_q;
  logic [6:0]            glyph_q;
  logic [15:0]           total_q;
  logic signed [15:0]    py_q;
  logic [COORD_BITS-1:0] px_q;
  logic [7:0]            dw_q;
  logic                  out_fire;
  logic                  load;
  logic [COORD_BITS:0]   px_sum;
  logic [COORD_BITS-1:0] px_next;
  logic [31:0]           px_wide;

  // Advance the dot pen by the dot width, saturating at the positive limit
  always_comb begin
    px_sum  = {px_q[COORD_BITS-1], px_q} + (COORD_BITS + 1)'(dw_q);
    px_next = (px_sum[COORD_BITS] != px_sum[COORD_BITS-1]) ? PEN_MAX
                                                            : px_sum[COORD_BITS-1:0];
  end

  assign out_fire = ov_q && !out_stall_i;
  assign ready_o  = !ov_q || (out_fire && (cnt_q == 2'd0));
  assign load     = req_i.valid && ready_o;

  // Load a request, then step through any dots before the final result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else if (load) begin
      ov_q  <= 1'b1;
      cnt_q <= (req_i.is_end && req_i.trunc) ? DOT_COUNT : 2'd0;
    end else if (out_fire) begin
      if (cnt_q != 2'd0) begin
        cnt_q <= cnt_q - 2'd1;
      end else begin
        ov_q <= 1'b0;
      end
    end
  end

  // Hold the payload of the current request
  always_ff @(posedge clk_i) begin
    if (load) begin
      is_end_q <= req_i.is_end;
      trunc_q  <= req_i.trunc;
      glyph_q  <= req_i.glyph;
      total_q  <= req_i.total;
      py_q     <= req_i.pen_y;
      px_q     <= pen_x_i;
      dw_q     <= dot_w_i;
    end else if (out_fire && (cnt_q != 2'd0)) begin
      px_q <= px_next;
    end
  end

  assign px_wide     = 32'($signed(px_q));
  assign out_valid_o = ov_q;

  // Format the current result
  always_comb begin
    out_item_o = '0;
    if (cnt_q != 2'd0) begin
      out_item_o.result_kind = RES_DRAW;
      out_item_o.glyph_index = 7'(DOT_GLYPH);
      out_item_o.pen_x       = px_wide[15:0];
      out_item_o.pen_y       = py_q;
      out_item_o.last_result = 1'b0;
    end else if (is_end_q) begin
      out_item_o.result_kind   = RES_DONE;
      out_item_o.total_width   = total_q;
      out_item_o.was_truncated = trunc_q;
      out_item_o.last_result   = 1'b1;
    end else begin
      out_item_o.result_kind = RES_DRAW;
      out_item_o.glyph_index = glyph_q;
      out_item_o.pen_x       = px_wide[15:0];
      out_item_o.pen_y       = py_q;
      out_item_o.last_result = 1'b1;
    end
  end

endmodule

/* dv/layout_checker.sv */
`timescale 1ns / 100ps

module layout_checker
  import tle_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  in_item_t    in_item_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  out_item_t   out_item_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [11:0] cfg_data_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          checked_o,
  output int          ellipsis_o
);

  localparam int GLYPHS      = 96;
  localparam int PEN_MAX     = 32767;
  localparam int PEN_MIN     = -32768;
  localparam int SUM_MAX     = 65535;
  localparam int PRINT_LIMIT = 40;

  // Shadow copy of the layout engine
  logic [7:0]  glyph_widths [GLYPHS];
  int          pen_x;
  int          pen_y;
  int          budget;
  int          width_sum;
  logic [1:0]  layout_mode;
  logic [11:0] display_width;

  out_item_t   layout_q [$];
  int          errors        = 0;
  int          checked       = 0;
  int          ellipsis_runs = 0;

  function automatic int sat_pen(int v);
    if (v > PEN_MAX) return PEN_MAX;
    if (v < PEN_MIN) return PEN_MIN;
    return v;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (errors < PRINT_LIMIT)
      $display("[%0t] mismatch on %s: got %0h, expected %0h", $time, what, got, want);
    errors++;
  endtask

  task automatic push_result(logic kind, logic [6:0] glyph, int px, int py, int total,
                             logic trunc, logic last);
    out_item_t r;
    r = '0;
    r.result_kind   = kind;
    r.glyph_index   = glyph;
    r.pen_x         = px[15:0];
    r.pen_y         = py[15:0];
    r.total_width   = total[15:0];
    r.was_truncated = trunc;
    r.last_result   = last;
    layout_q.push_back(r);
  endtask

  task automatic reset_engine();
    pen_x         = 0;
    pen_y         = 0;
    budget        = 0;
    width_sum     = 0;
    layout_mode   = LAYOUT_MODE_RST;
    display_width = DISPLAY_WIDTH_RST;
    layout_q.delete();
  endtask

  // Work out the draw commands and done report caused by one item
  task automatic lay_out_item(in_item_t it);
    int   g;
    int   w;
    int   px;
    int   dot_w;
    logic clipped;
    logic draws;
    logic keep;
    logic trunc;
    clipped = (layout_mode == MODE_CLIPPED);
    draws   = (layout_mode == MODE_PLAIN) || clipped;
    case (it.operation)
      OP_LOAD: begin
        if (it.char_code < GLYPHS) glyph_widths[it.char_code] = it.glyph_width;
      end
      OP_START: begin
        pen_x     = $signed(it.start_x);
        pen_y     = $signed(it.start_y);
        width_sum = 0;
        budget    = int'(display_width) - int'($signed(it.start_x))
                    - 3 * int'(glyph_widths[DOT_GLYPH]);
      end
      OP_CHAR: begin
        if (it.char_code >= FIRST_CODE) begin
          g = int'(it.char_code) - int'(FIRST_CODE);
          if (g < GLYPHS) begin
            w    = int'(glyph_widths[g]);
            keep = 1'b1;
            // Clipped: skip once the budget is spent, drop the glyph that spends it
            if (clipped) begin
              if (budget <= 0) keep = 1'b0;
              else begin
                budget -= w;
                if (budget <= 0) keep = 1'b0;
              end
            end
            if (keep) begin
              if (draws && g != 0) push_result(RES_DRAW, 7'(g), pen_x, pen_y, 0, 1'b0, 1'b1);
              pen_x     = sat_pen(pen_x + w);
              width_sum = (width_sum + w > SUM_MAX) ? SUM_MAX : width_sum + w;
            end
          end
        end
      end
      default: begin
        trunc = 1'b0;
        if (clipped && budget <= 0) begin
          dot_w = int'(glyph_widths[DOT_GLYPH]);
          px    = pen_x;
          repeat (DOT_COUNT) begin
            push_result(RES_DRAW, 7'(DOT_GLYPH), px, pen_y, 0, 1'b0, 1'b0);
            px = sat_pen(px + dot_w);
          end
          trunc = 1'b1;
          ellipsis_runs++;
        end
        push_result(RES_DONE, '0, 0, 0, width_sum, trunc, 1'b1);
      end
    endcase
  endtask

  task automatic check_result(out_item_t got);
    out_item_t want;
    if (layout_q.size() == 0) begin
      report_mismatch("result with nothing expected", 32'(got), '0);
    end else begin
      want = layout_q.pop_front();
      checked++;
      if (got.result_kind !== want.result_kind)
        report_mismatch("result_kind", 32'(got.result_kind), 32'(want.result_kind));
      if (got.glyph_index !== want.glyph_index)
        report_mismatch("glyph_index", 32'(got.glyph_index), 32'(want.glyph_index));
      if (got.pen_x !== want.pen_x)
        report_mismatch("pen_x", 32'(got.pen_x), 32'(want.pen_x));
      if (got.pen_y !== want.pen_y)
        report_mismatch("pen_y", 32'(got.pen_y), 32'(want.pen_y));
      if (got.total_width !== want.total_width)
        report_mismatch("total_width", 32'(got.total_width), 32'(want.total_width));
      if (got.was_truncated !== want.was_truncated)
        report_mismatch("was_truncated", 32'(got.was_truncated),
                        32'(want.was_truncated));
      if (got.last_result !== want.last_result)
        report_mismatch("last_result", 32'(got.last_result), 32'(want.last_result));
    end
  endtask

  // Watch all three channels; results go first so they never meet the item of this edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reset_engine();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == CFG_LAYOUT_MODE) layout_mode = cfg_data_i[1:0];
        else if (cfg_index_i == CFG_DISPLAY_WIDTH) display_width = cfg_data_i;
      end
      if (out_valid_i && !out_stall_i) check_result(out_item_i);
      if (in_valid_i && !in_stall_i) lay_out_item(in_item_i);
    end
    fail_count_o <= errors;
    pending_o    <= layout_q.size();
    checked_o    <= checked;
    ellipsis_o   <= ellipsis_runs;
  end

endmodule

/* dv/testbench.sv */
`timescale 1ns / 100ps

module testbench;
  import tle_pkg::*;

  localparam logic [1:0] MODE_SPARE    = 2'd3;
  localparam int         SETTLE_CYCLES = 12;
  localparam int         SEGMENTS      = 6;
  localparam int         SEGMENT_ITEMS = 12;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  in_item_t    in_item   = '0;
  logic        in_stall;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_item;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [11:0] cfg_data  = '0;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int items_sent    = 0;
  int settings_used = 0;
  int fail_count;
  int pending;
  int checked;
  int ellipsis;

  text_layout_with_ellipsis uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  layout_checker checker_i (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_item_i    (in_item),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_item_i   (out_item),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked),
    .ellipsis_o   (ellipsis)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // Receiver stalls at random
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  // Offer one item, idling first at random, and hold it until taken
  task automatic send(logic [1:0] op, logic [7:0] code, logic [7:0] wid,
                      logic [15:0] x, logic [15:0] y);
    in_item_t it;
    it.operation   = op;
    it.char_code   = code;
    it.glyph_width = wid;
    it.start_x     = x;
    it.start_y     = y;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (!(op == OP_CHAR && (code < FIRST_CODE || code >= 8'd128)) &&
        !(op == OP_LOAD && code >= 8'd96))
      items_sent++;
  endtask

  task automatic load_width(logic [7:0] idx, logic [7:0] wid);
    send(OP_LOAD, idx, wid, 16'($urandom()), 16'($urandom()));
  endtask

  task automatic start_text(logic [15:0] x, logic [15:0] y);
    send(OP_START, 8'($urandom()), 8'($urandom()), x, y);
  endtask

  task automatic put_char(logic [7:0] code);
    send(OP_CHAR, code, 8'($urandom()), 16'($urandom()), 16'($urandom()));
  endtask

  task automatic end_text();
    send(OP_END, 8'($urandom()), 8'($urandom()), 16'($urandom()), 16'($urandom()));
  endtask

  // Hold the sender until every expected result has come
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic configure(logic [1:0] mode, logic [11:0] width);
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_LAYOUT_MODE;
    cfg_data  <= {10'd0, mode};
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_index <= CFG_DISPLAY_WIDTH;
    cfg_data  <= width;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
    settings_used++;
  endtask

  function automatic logic [7:0] pick_code();
    if ($urandom_range(0, 99) < 85) return 8'($urandom_range(32, 127));
    return 8'($urandom_range(0, 255));
  endfunction

  // Start, characters, and usually an end; some texts are left open
  task automatic random_text();
    int          n;
    logic [15:0] x;
    x = ($urandom_range(0, 3) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 400));
    n = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 12);
    start_text(x, 16'($urandom()));
    repeat (n) put_char(pick_code());
    if ($urandom_range(0, 9) != 0) end_text();
  endtask

  initial begin
    int          goal;
    int          roll;
    logic [11:0] width;
    bit          paused = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // End item before any text, on the reset state
    end_text();

    // Fill the width table: zero and full widths included, plus ignored indexes
    for (int i = 0; i < 96; i++) begin
      if (i == 1) load_width(8'(i), 8'd0);
      else if (i == 95) load_width(8'(i), 8'd255);
      else if (i == DOT_GLYPH) load_width(8'(i), 8'd3);
      else load_width(8'(i), 8'($urandom_range(1, 16)));
    end
    load_width(8'd96, 8'hAA);
    load_width(8'd255, 8'h55);

    // Plain mode: character before any start, extreme coordinates, ignored codes
    put_char("H");
    start_text(16'h8000, 16'h7FFF);
    put_char(" ");
    put_char("A");
    put_char("!");
    put_char(8'h00);
    put_char(8'hFF);
    put_char(8'h1F);
    put_char(8'h80);
    put_char(8'h7F);
    put_char(".");
    end_text();

    // Pen x runs into its upper limit
    start_text(16'd32700, 16'h8000);
    put_char(8'h7F);
    put_char(8'h7F);
    put_char("A");
    end_text();

    // Clipped with the narrowest display: ellipsis without any glyph
    configure(MODE_CLIPPED, 12'd1);
    start_text(16'd0, 16'd0);
    put_char("A");
    put_char("B");
    end_text();

    // Clipped with the widest display: one text fits, one is cut
    configure(MODE_CLIPPED, 12'd4095);
    start_text(16'd0, 16'd7);
    put_char("A");
    put_char("B");
    end_text();
    start_text(16'd4000, 16'd5);
    repeat (6) put_char(pick_code());
    put_char(8'h7F);
    put_char("A");
    end_text();

    // Measure mode: the width sum saturates
    configure(MODE_MEASURE, 12'd320);
    start_text(16'd0, 16'd0);
    repeat (260) put_char(8'h7F);
    end_text();

    // Spare mode code acts as measure
    configure(MODE_SPARE, 12'd4095);
    start_text(16'd10, 16'd10);
    put_char("A");
    put_char(" ");
    put_char("B");
    end_text();

    // Random segments, each under a fresh setting and an idling profile
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      roll = $urandom_range(0, 3);
      width = (roll == 0) ? 12'd1 : (roll == 1) ? 12'd4095 :
              (roll == 2) ? 12'd320 : 12'($urandom_range(1, 4095));
      configure(2'($urandom_range(0, 3)), width);
      if (seg < 2) begin
        send_idle_pct = 36;
        recv_idle_pct = 45;
      end else if (seg < 4) begin
        send_idle_pct = 45;
        recv_idle_pct = 36;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      goal = items_sent + SEGMENT_ITEMS;
      while (items_sent < goal) begin
        roll = $urandom_range(0, 99);
        if (roll < 80) random_text();
        else if (roll < 88)
          load_width(8'($urandom()), ($urandom_range(0, 1) == 0) ?
                     8'($urandom_range(0, 20)) : 8'($urandom()));
        else if (roll < 94) put_char(8'($urandom()));
        else end_text();
        if (seg == 1 && items_sent >= goal - SEGMENT_ITEMS / 2 && !paused) begin
          drain();
          paused = 1'b1;
        end
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Sent %0d items over %0d register settings in all four mode codes.",
             items_sent, settings_used);
    $display("Checked %0d results, %0d of them texts cut with an ellipsis.",
             checked, ellipsis);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
